@@ hdl/hvd_pkg.sv @@
package hvd_pkg;

  localparam int LAT_W = 31;
  localparam int LON_W = 32;
  localparam int RAD_W = 23;
  localparam int DIST_W = 32;
  localparam int MAG_W = 36;
  localparam int ANG_W = 37;
  localparam int XY_W = 34;
  localparam int SQ_IN_W = 61;
  localparam int SQ_W = 62;
  localparam int SQ_RES_W = 31;
  localparam int SQ_STEPS = 31;
  localparam int FRAC_W = 30;
  localparam int ZC_W = 33;
  localparam int R100_W = 30;
  localparam int PROD_W = 63;

  localparam logic [63:0] DEG2RAD_K = 64'd2398762259;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q32 = 37'sd6746518852;
  localparam logic signed [ANG_W-1:0] PI_Q32 = 37'sd13493037704;
  localparam logic signed [ANG_W-1:0] TWO_PI_Q32 = 37'sd26986075409;
  localparam logic signed [XY_W-1:0] CORDIC_GAIN_Q30 = 34'sd652032874;
  localparam logic [SQ_RES_W-1:0] ONE_Q30 = 31'd1073741824;
  localparam logic [RAD_W-1:0] RADIUS_RESET = 23'd6371000;

  // magnitude of a sign-extended field
  function automatic logic [31:0] abs_mag(input logic signed [32:0] v);
    logic signed [32:0] n;
    n = -v;
    return v[32] ? n[31:0] : v[31:0];
  endfunction

  // degrees times 2^23 to radians in q.32, magnitude only
  function automatic logic [MAG_W-1:0] rad_mag(input logic [31:0] mag);
    logic [63:0] p;
    p = 64'(mag) * DEG2RAD_K + (64'd1 << 27);
    return p[MAG_W+27:28];
  endfunction

  // atan(2^-i) in q.32 from the arctangent series
  function automatic logic [63:0] atan_entry(input int unsigned i);
    logic [63:0] sum;
    logic [63:0] term;
    int unsigned e;
    sum = 64'd0;
    if (i == 0) begin
      return 64'd3373259426;
    end
    if (i > 32) begin
      return 64'd0;
    end
    for (int unsigned k = 0; k < 61; k++) begin
      e = i * (2 * k + 1);
      if (e <= 60) begin
        term = (64'd1 << (60 - e)) / 64'(2 * k + 1);
        if (k[0]) begin
          sum = sum - term;
        end else begin
          sum = sum + term;
        end
      end
    end
    return (sum + (64'd1 << 27)) >> 28;
  endfunction

endpackage

@@ hdl/hvd_sincos.sv @@
module hvd_sincos #(
  parameter int STAGES = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic signed [hvd_pkg::ANG_W-1:0] ang,
  output logic out_valid,
  output logic signed [hvd_pkg::XY_W-1:0] sin_val,
  output logic signed [hvd_pkg::XY_W-1:0] cos_val
);
  import hvd_pkg::*;

  logic v0, v1, v2;
  logic signed [ANG_W-1:0] r0, r1, r2;
  logic neg2;
  logic signed [ANG_W-1:0] r0_next, r1_next, r2_next;
  logic neg2_next;

  logic signed [XY_W-1:0] x [0:STAGES];
  logic signed [XY_W-1:0] y [0:STAGES];
  logic signed [ANG_W-1:0] z [0:STAGES];
  logic ng [0:STAGES];
  logic vl [0:STAGES];

  // remainder by two pi
  always_comb begin
    r0_next = ang;
    if (ang >= TWO_PI_Q32) begin
      r0_next = ang - TWO_PI_Q32;
    end else if (ang <= -TWO_PI_Q32) begin
      r0_next = ang + TWO_PI_Q32;
    end
  end

  // fold into -pi..pi
  always_comb begin
    r1_next = r0;
    if (r0 > PI_Q32) begin
      r1_next = r0 - TWO_PI_Q32;
    end else if (r0 < -PI_Q32) begin
      r1_next = r0 + TWO_PI_Q32;
    end
  end

  // fold into -pi/2..pi/2 with sign flip
  always_comb begin
    r2_next = r1;
    neg2_next = 1'b0;
    if (r1 > HALF_PI_Q32) begin
      r2_next = r1 - PI_Q32;
      neg2_next = 1'b1;
    end else if (r1 < -HALF_PI_Q32) begin
      r2_next = r1 + PI_Q32;
      neg2_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r0 <= r0_next;
      r1 <= r1_next;
      r2 <= r2_next;
      neg2 <= neg2_next;
    end
  end

  assign x[0] = CORDIC_GAIN_Q30;
  assign y[0] = '0;
  assign z[0] = r2;
  assign ng[0] = neg2;
  assign vl[0] = v2;

  for (genvar i = 0; i < STAGES; i++) begin : g_rot
    localparam logic [63:0] TAB64 = atan_entry(i);
    localparam logic signed [ANG_W-1:0] TAB = signed'(TAB64[ANG_W-1:0]);

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[i+1] <= 1'b0;
      end else if (en) begin
        vl[i+1] <= vl[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        ng[i+1] <= ng[i];
        if (z[i] >= 0) begin
          x[i+1] <= x[i] - (y[i] >>> i);
          y[i+1] <= y[i] + (x[i] >>> i);
          z[i+1] <= z[i] - TAB;
        end else begin
          x[i+1] <= x[i] + (y[i] >>> i);
          y[i+1] <= y[i] - (x[i] >>> i);
          z[i+1] <= z[i] + TAB;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vl[STAGES];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sin_val <= ng[STAGES] ? -y[STAGES] : y[STAGES];
      cos_val <= ng[STAGES] ? -x[STAGES] : x[STAGES];
    end
  end

endmodule

@@ hdl/hvd_isqrt.sv @@
module hvd_isqrt (
  input  logic clk,
  input  logic rst,
  input  logic en,
  input  logic in_valid,
  input  logic [hvd_pkg::SQ_IN_W-1:0] val,
  output logic out_valid,
  output logic [hvd_pkg::SQ_RES_W-1:0] root
);
  import hvd_pkg::*;

  logic [SQ_W-1:0] rem [0:SQ_STEPS];
  logic [SQ_W-1:0] res [0:SQ_STEPS];
  logic vl [0:SQ_STEPS];

  assign rem[0] = SQ_W'(val);
  assign res[0] = '0;
  assign vl[0] = in_valid;

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_step
    localparam logic [SQ_W-1:0] BIT = SQ_W'(1) << (2 * (SQ_STEPS - 1 - k));
    logic [SQ_W-1:0] trial;

    assign trial = res[k] + BIT;

    always_ff @(posedge clk) begin
      if (rst) begin
        vl[k+1] <= 1'b0;
      end else if (en) begin
        vl[k+1] <= vl[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (rem[k] >= trial) begin
          rem[k+1] <= rem[k] - trial;
          res[k+1] <= (res[k] >> 1) + BIT;
        end else begin
          rem[k+1] <= rem[k];
          res[k+1] <= res[k] >> 1;
        end
      end
    end
  end

  assign out_valid = vl[SQ_STEPS];
  assign root = res[SQ_STEPS][SQ_RES_W-1:0];

endmodule

@@ hdl/haversine_distance.sv @@
// throughput: one item per cycle; the whole pipeline advances together and
// holds while the output register is full and not taken
// reset: rst synchronous active high, clears all valid bits and loads
// the radius register with 6371000
module haversine_distance #(
  parameter int CORDIC_STAGES = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [hvd_pkg::LAT_W-1:0] first_latitude,
  input  logic signed [hvd_pkg::LON_W-1:0] first_longitude,
  input  logic signed [hvd_pkg::LAT_W-1:0] second_latitude,
  input  logic signed [hvd_pkg::LON_W-1:0] second_longitude,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [hvd_pkg::RAD_W-1:0] earth_radius,
  output logic out_valid,
  input  logic out_ready,
  output logic [hvd_pkg::DIST_W-1:0] distance_cm
);
  import hvd_pkg::*;

  logic en;
  logic [RAD_W-1:0] radius;
  logic [R100_W-1:0] r100;

  logic v1, v2, v3;
  logic [MAG_W-1:0] m_lat1, m_lon1, m_lat2, m_lon2;
  logic n_lat1, n_lon1, n_lat2, n_lon2;
  logic signed [ANG_W-1:0] lat1, lon1, lat2, lon2;
  logic signed [ANG_W-1:0] a_dlat, a_dlon, a_lat1, a_lat2;

  logic sc_valid;
  logic signed [XY_W-1:0] sdl, sdn, c1, c2;

  logic pv1, pv2, pv3, pv4;
  logic signed [XY_W-1:0] t1_1, t1_2, t1_3, cc1, cc2, cc3, sdn1, sdn2;
  logic signed [2*XY_W-1:0] prod_t1, prod_cc1, prod_cc2, prod_cc3;
  logic signed [XY_W:0] a_sum;
  logic [SQ_RES_W-1:0] a_q, a_next;
  logic [SQ_RES_W-1:0] one_minus_a;

  logic sq_valid;
  logic [SQ_RES_W-1:0] root_y, root_x;

  logic signed [XY_W-1:0] vx [0:CORDIC_STAGES];
  logic signed [XY_W-1:0] vy [0:CORDIC_STAGES];
  logic signed [ANG_W-1:0] vz [0:CORDIC_STAGES];
  logic vv [0:CORDIC_STAGES];

  logic cv, mv;
  logic [ZC_W-1:0] zc;
  logic [PROD_W-1:0] prod;
  logic [63:0] rounded;

  assign en = !out_valid || out_ready;
  assign in_ready = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      radius <= RADIUS_RESET;
    end else if (cfg_valid) begin
      radius <= earth_radius;
    end
  end

  always_ff @(posedge clk) begin
    r100 <= R100_W'(radius) * R100_W'(100);
  end

  // degrees to radians and half differences of latitude and longitude
  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_lat1 <= rad_mag(abs_mag(33'(first_latitude)));
      m_lon1 <= rad_mag(abs_mag(33'(first_longitude)));
      m_lat2 <= rad_mag(abs_mag(33'(second_latitude)));
      m_lon2 <= rad_mag(abs_mag(33'(second_longitude)));
      n_lat1 <= first_latitude[LAT_W-1];
      n_lon1 <= first_longitude[LON_W-1];
      n_lat2 <= second_latitude[LAT_W-1];
      n_lon2 <= second_longitude[LON_W-1];
      lat1 <= n_lat1 ? -signed'({1'b0, m_lat1}) : signed'({1'b0, m_lat1});
      lon1 <= n_lon1 ? -signed'({1'b0, m_lon1}) : signed'({1'b0, m_lon1});
      lat2 <= n_lat2 ? -signed'({1'b0, m_lat2}) : signed'({1'b0, m_lat2});
      lon2 <= n_lon2 ? -signed'({1'b0, m_lon2}) : signed'({1'b0, m_lon2});
      a_dlat <= (lat2 - lat1) >>> 1;
      a_dlon <= (lon2 - lon1) >>> 1;
      a_lat1 <= lat1;
      a_lat2 <= lat2;
    end
  end

  hvd_sincos #(.STAGES(CORDIC_STAGES)) u_sc_dlat (
    .clk(clk), .rst(rst), .en(en), .in_valid(v3), .ang(a_dlat),
    .out_valid(sc_valid), .sin_val(sdl), .cos_val()
  );

  hvd_sincos #(.STAGES(CORDIC_STAGES)) u_sc_dlon (
    .clk(clk), .rst(rst), .en(en), .in_valid(v3), .ang(a_dlon),
    .out_valid(), .sin_val(sdn), .cos_val()
  );

  hvd_sincos #(.STAGES(CORDIC_STAGES)) u_sc_lat1 (
    .clk(clk), .rst(rst), .en(en), .in_valid(v3), .ang(a_lat1),
    .out_valid(), .sin_val(), .cos_val(c1)
  );

  hvd_sincos #(.STAGES(CORDIC_STAGES)) u_sc_lat2 (
    .clk(clk), .rst(rst), .en(en), .in_valid(v3), .ang(a_lat2),
    .out_valid(), .sin_val(), .cos_val(c2)
  );

  // haversine term
  assign prod_t1 = sdl * sdl;
  assign prod_cc1 = c1 * c2;
  assign prod_cc2 = cc1 * sdn1;
  assign prod_cc3 = cc2 * sdn2;
  assign a_sum = (XY_W+1)'(t1_3) + (XY_W+1)'(cc3);

  always_comb begin
    if (a_sum < 0) begin
      a_next = '0;
    end else if (a_sum > signed'((XY_W+1)'(ONE_Q30))) begin
      a_next = ONE_Q30;
    end else begin
      a_next = a_sum[SQ_RES_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pv1 <= 1'b0;
      pv2 <= 1'b0;
      pv3 <= 1'b0;
      pv4 <= 1'b0;
    end else if (en) begin
      pv1 <= sc_valid;
      pv2 <= pv1;
      pv3 <= pv2;
      pv4 <= pv3;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      t1_1 <= prod_t1[XY_W+FRAC_W-1:FRAC_W];
      cc1 <= prod_cc1[XY_W+FRAC_W-1:FRAC_W];
      sdn1 <= sdn;
      t1_2 <= t1_1;
      cc2 <= prod_cc2[XY_W+FRAC_W-1:FRAC_W];
      sdn2 <= sdn1;
      t1_3 <= t1_2;
      cc3 <= prod_cc3[XY_W+FRAC_W-1:FRAC_W];
      a_q <= a_next;
    end
  end

  assign one_minus_a = ONE_Q30 - a_q;

  hvd_isqrt u_sq_y (
    .clk(clk), .rst(rst), .en(en), .in_valid(pv4), .val({a_q, {FRAC_W{1'b0}}}),
    .out_valid(sq_valid), .root(root_y)
  );

  hvd_isqrt u_sq_x (
    .clk(clk), .rst(rst), .en(en), .in_valid(pv4),
    .val({one_minus_a, {FRAC_W{1'b0}}}),
    .out_valid(), .root(root_x)
  );

  // half the central angle by vectoring
  assign vx[0] = signed'({{(XY_W-SQ_RES_W){1'b0}}, root_x});
  assign vy[0] = signed'({{(XY_W-SQ_RES_W){1'b0}}, root_y});
  assign vz[0] = '0;
  assign vv[0] = sq_valid;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_vec
    localparam logic [63:0] TAB64 = atan_entry(i);
    localparam logic signed [ANG_W-1:0] TAB = signed'(TAB64[ANG_W-1:0]);

    always_ff @(posedge clk) begin
      if (rst) begin
        vv[i+1] <= 1'b0;
      end else if (en) begin
        vv[i+1] <= vv[i];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        if (vy[i] > 0) begin
          vx[i+1] <= vx[i] + (vy[i] >>> i);
          vy[i+1] <= vy[i] - (vx[i] >>> i);
          vz[i+1] <= vz[i] + TAB;
        end else begin
          vx[i+1] <= vx[i] - (vy[i] >>> i);
          vy[i+1] <= vy[i] + (vx[i] >>> i);
          vz[i+1] <= vz[i] - TAB;
        end
      end
    end
  end

  // clamp, scale, round
  assign rounded = {1'b0, prod} + (64'd1 << 30);

  always_ff @(posedge clk) begin
    if (rst) begin
      cv <= 1'b0;
      mv <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      cv <= vv[CORDIC_STAGES];
      mv <= cv;
      out_valid <= mv;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (vz[CORDIC_STAGES] < 0) begin
        zc <= '0;
      end else if (vz[CORDIC_STAGES] > HALF_PI_Q32) begin
        zc <= HALF_PI_Q32[ZC_W-1:0];
      end else begin
        zc <= vz[CORDIC_STAGES][ZC_W-1:0];
      end
      prod <= PROD_W'(r100) * PROD_W'(zc);
      distance_cm <= rounded[DIST_W+30:31];
    end
  end

endmodule

@@ bench/tb_top.sv @@
`timescale 1ns / 100ps

module tb_top;
  import hvd_pkg::*;

  localparam int STAGES = 32;
  localparam int LATENCY = 2 * STAGES + 45;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int N_DIRECTED = 14;
  localparam logic [RAD_W-1:0] RADIUS_MAX = 23'd8000000;
  localparam logic [RAD_W-1:0] RADIUS_MIN = 23'd1;
  localparam logic [RAD_W-1:0] RADIUS_ZERO = 23'd0;
  localparam logic [RAD_W-1:0] RADIUS_ALL_ONES = 23'h7fffff;
  localparam longint LAT_MAX = 754974720;
  localparam longint LON_MAX = 1509949440;
  localparam longint NO_CHECK = -1;

  typedef struct {
    logic signed [LAT_W-1:0] lat1;
    logic signed [LON_W-1:0] lon1;
    logic signed [LAT_W-1:0] lat2;
    logic signed [LON_W-1:0] lon2;
    longint want;
  } route_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [LAT_W-1:0] first_latitude = '0;
  logic signed [LON_W-1:0] first_longitude = '0;
  logic signed [LAT_W-1:0] second_latitude = '0;
  logic signed [LON_W-1:0] second_longitude = '0;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [RAD_W-1:0] earth_radius = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [DIST_W-1:0] distance_cm;

  logic [RAD_W-1:0] radius_now;
  longint arctan_tab[48];
  logic [DIST_W-1:0] expected_distances[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  bit hold_receiver = 1'b0;
  route_t directed[N_DIRECTED];

  haversine_distance #(.CORDIC_STAGES(STAGES)) uut (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .first_latitude(first_latitude),
    .first_longitude(first_longitude),
    .second_latitude(second_latitude),
    .second_longitude(second_longitude),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .earth_radius(earth_radius),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .distance_cm(distance_cm)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic longint shr_floor(longint v, int n);
    return v >>> n;
  endfunction

  function automatic longint deg_to_rad(longint d);
    longint unsigned m;
    longint r;
    m = d < 0 ? -d : d;
    r = longint'((m * 64'd2398762259 + (64'd1 << 27)) >> 28);
    return d < 0 ? -r : r;
  endfunction

  function automatic longint arctan_q32(int i);
    longint unsigned sum;
    int k;
    int e;
    sum = 0;
    if (i == 0) return 64'd3373259426;
    if (i > 32) return 0;
    k = 0;
    forever begin
      e = i * (2 * k + 1);
      if (e > 60) break;
      if (k % 2 == 1) sum -= (64'd1 << (60 - e)) / (2 * k + 1);
      else sum += (64'd1 << (60 - e)) / (2 * k + 1);
      k++;
    end
    return longint'((sum + (64'd1 << 27)) >> 28);
  endfunction

  task automatic sin_cos_q30(input longint ang, output longint s, output longint c);
    longint r;
    longint x;
    longint y;
    longint dx;
    longint dy;
    bit flip;
    r = ang % longint'(TWO_PI_Q32);
    x = 652032874;
    y = 0;
    flip = 1'b0;
    if (r > longint'(PI_Q32)) r -= longint'(TWO_PI_Q32);
    if (r < -longint'(PI_Q32)) r += longint'(TWO_PI_Q32);
    if (r > longint'(HALF_PI_Q32)) begin
      r -= longint'(PI_Q32);
      flip = 1'b1;
    end else if (r < -longint'(HALF_PI_Q32)) begin
      r += longint'(PI_Q32);
      flip = 1'b1;
    end
    for (int i = 0; i < STAGES; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (r >= 0) begin
        x -= dx;
        y += dy;
        r -= arctan_tab[i];
      end else begin
        x += dx;
        y -= dy;
        r += arctan_tab[i];
      end
    end
    s = flip ? -y : y;
    c = flip ? -x : x;
  endtask

  function automatic longint floor_sqrt(longint unsigned v);
    longint unsigned res;
    longint unsigned b;
    res = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= res + b) begin
        v -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return longint'(res);
  endfunction

  task automatic predict_distance(input route_t rt, output logic [DIST_W-1:0] result);
    longint la1;
    longint lo1;
    longint la2;
    longint lo2;
    longint sdl;
    longint cdl;
    longint sdn;
    longint cdn;
    longint s1;
    longint c1;
    longint s2;
    longint c2;
    longint a;
    longint cc;
    longint x;
    longint y;
    longint z;
    longint dx;
    longint dy;
    longint unsigned prod;
    la1 = deg_to_rad(longint'(rt.lat1));
    lo1 = deg_to_rad(longint'(rt.lon1));
    la2 = deg_to_rad(longint'(rt.lat2));
    lo2 = deg_to_rad(longint'(rt.lon2));
    sin_cos_q30(shr_floor(la2 - la1, 1), sdl, cdl);
    sin_cos_q30(shr_floor(lo2 - lo1, 1), sdn, cdn);
    sin_cos_q30(la1, s1, c1);
    sin_cos_q30(la2, s2, c2);
    cc = shr_floor(c1 * c2, 30);
    cc = shr_floor(cc * sdn, 30);
    cc = shr_floor(cc * sdn, 30);
    a = shr_floor(sdl * sdl, 30) + cc;
    if (a < 0) a = 0;
    if (a > 64'd1073741824) a = 64'd1073741824;
    y = floor_sqrt(longint'(a) << 30);
    x = floor_sqrt((64'd1073741824 - a) << 30);
    z = 0;
    for (int i = 0; i < STAGES; i++) begin
      dx = shr_floor(y, i);
      dy = shr_floor(x, i);
      if (y > 0) begin
        x += dx;
        y -= dy;
        z += arctan_tab[i];
      end else begin
        x -= dx;
        y += dy;
        z -= arctan_tab[i];
      end
    end
    if (z < 0) z = 0;
    if (z > longint'(HALF_PI_Q32)) z = HALF_PI_Q32;
    prod = (64'(radius_now) * 100 * z + (64'd1 << 30)) >> 31;
    result = prod[31:0];
  endtask

  function automatic route_t make_route(longint la1, longint lo1, longint la2, longint lo2,
                                        longint want);
    route_t rt;
    rt.lat1 = LAT_W'(la1);
    rt.lon1 = LON_W'(lo1);
    rt.lat2 = LAT_W'(la2);
    rt.lon2 = LON_W'(lo2);
    rt.want = want;
    return rt;
  endfunction

  function automatic route_t random_route();
    longint la1;
    longint lo1;
    longint la2;
    longint lo2;
    int kind;
    kind = $urandom_range(0, 9);
    la1 = longint'($urandom_range(0, 32'(2 * LAT_MAX))) - LAT_MAX;
    lo1 = longint'($urandom_range(0, 32'hffffffff)) % (LON_MAX + 1);
    if ($urandom_range(0, 1)) lo1 = -lo1;
    la2 = longint'($urandom_range(0, 32'(2 * LAT_MAX))) - LAT_MAX;
    lo2 = longint'($urandom_range(0, 32'hffffffff)) % (LON_MAX + 1);
    if ($urandom_range(0, 1)) lo2 = -lo2;
    if (kind == 0) begin
      // full raw range, out-of-range angles included
      la1 = longint'($urandom());
      lo1 = longint'($urandom());
      la2 = longint'($urandom());
      lo2 = longint'($urandom());
    end else if (kind == 1) begin
      // nearby points
      la2 = la1 + longint'($urandom_range(0, 2000)) - 1000;
      lo2 = lo1 + longint'($urandom_range(0, 2000)) - 1000;
    end else if (kind == 2) begin
      // near antipodal
      la2 = -la1 + longint'($urandom_range(0, 200)) - 100;
      lo2 = lo1 + (lo1 < 0 ? LON_MAX : -LON_MAX);
    end
    return make_route(la1, lo1, la2, lo2, NO_CHECK);
  endfunction

  task automatic send_route(input route_t rt);
    logic [DIST_W-1:0] want;
    if (send_idle_pct != 0) begin
      while ($urandom_range(0, 99) < send_idle_pct) begin
        in_valid <= 1'b0;
        @(posedge clk);
      end
    end
    in_valid <= 1'b1;
    first_latitude <= rt.lat1;
    first_longitude <= rt.lon1;
    second_latitude <= rt.lat2;
    second_longitude <= rt.lon2;
    predict_distance(rt, want);
    expected_distances.push_back(want);
    if (rt.want != NO_CHECK && want != rt.want[31:0]) begin
      mismatches++;
      if (mismatches <= 10)
        $display("directed row predicted %0d, table says %0d", want, rt.want);
    end
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_distances.size() != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  task automatic write_radius(input logic [RAD_W-1:0] value);
    cfg_valid <= 1'b1;
    earth_radius <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    radius_now = value;
  endtask

  task automatic random_block(input int count);
    for (int i = 0; i < count; i++) send_route(random_route());
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= !hold_receiver && ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (!rst && out_valid && out_ready) begin
      if (expected_distances.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("distance item %0d with nothing expected", distance_cm);
      end else begin
        if (distance_cm !== expected_distances[0]) begin
          mismatches++;
          if (mismatches <= 10)
            $display("distance_cm expected %0d got %0d", expected_distances[0], distance_cm);
        end
        void'(expected_distances.pop_front());
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready) || rst)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < 48; i++) arctan_tab[i] = arctan_q32(i);
    radius_now = RADIUS_RESET;
    directed[0] = make_route(0, 0, 0, 0, NO_CHECK);
    directed[1] = make_route(LAT_MAX, LON_MAX, LAT_MAX, LON_MAX, NO_CHECK);
    directed[2] = make_route(-LAT_MAX, -LON_MAX, -LAT_MAX, -LON_MAX, NO_CHECK);
    directed[3] = make_route(LAT_MAX, 0, -LAT_MAX, 0, NO_CHECK);
    directed[4] = make_route(0, 0, 0, LON_MAX, NO_CHECK);
    directed[5] = make_route(0, -LON_MAX, 0, LON_MAX, NO_CHECK);
    directed[6] = make_route(0, 0, 0, 1, NO_CHECK);
    directed[7] = make_route(31'h3fffffff, 32'h7fffffff, 31'h40000000, 32'h80000000, NO_CHECK);
    directed[8] = make_route(31'h40000000, 32'h80000000, 31'h3fffffff, 32'h7fffffff, NO_CHECK);
    directed[9] = make_route(-1, -1, 1, 1, NO_CHECK);
    directed[10] = make_route(LAT_MAX, LON_MAX, -LAT_MAX, -LON_MAX, NO_CHECK);
    directed[11] = make_route(31'h55555555, 32'haaaaaaaa, 31'h2aaaaaaa, 32'h55555555, NO_CHECK);
    directed[12] = make_route(419430400, 838860800, -419430400, -838860800, NO_CHECK);
    directed[13] = make_route(100, 0, 0, 100, NO_CHECK);
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed[i]) send_route(directed[i]);
    wait_drained();

    write_radius(RADIUS_MAX);
    foreach (directed[i]) send_route(directed[i]);
    random_block(150);
    wait_drained();

    write_radius(RADIUS_ZERO);
    directed[10].want = 0;
    send_route(directed[10]);
    random_block(20);
    wait_drained();

    write_radius(RADIUS_MIN);
    send_idle_pct = 54;
    random_block(150);
    wait_drained();

    write_radius(RADIUS_ALL_ONES);
    send_idle_pct = 0;
    recv_stall_pct = 54;
    random_block(150);
    wait_drained();

    write_radius(RADIUS_RESET);
    send_idle_pct = 25;
    recv_stall_pct = 25;
    random_block(150);
    wait_drained();

    // long receiver hold-off so the pipeline backs up into the input
    write_radius(23'($urandom_range(1, 8000000)));
    send_idle_pct = 0;
    recv_stall_pct = 0;
    fork
      begin
        hold_receiver = 1'b1;
        repeat (3 * LATENCY) @(posedge clk);
        hold_receiver = 1'b0;
      end
      random_block(250);
    join
    wait_drained();

    write_radius(23'($urandom_range(1, 8000000)));
    recv_stall_pct = 54;
    random_block(150);
    wait_drained();

    if (mismatches == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
